// ----- src/mvf_pkg.sv -----
package mvf_pkg;

  // built vertex limit and derived widths
  localparam int MAX_VERTICES = 32;
  localparam int VTX_W        = $clog2(MAX_VERTICES);
  localparam int CNT_W        = VTX_W + 1;
  localparam int ROW_W        = MAX_VERTICES;

  typedef logic [VTX_W-1:0] vtx_t;
  typedef logic [CNT_W-1:0] cnt_t;
  typedef logic [ROW_W-1:0] row_t;

  // vertex count after reset
  localparam cnt_t COUNT_RESET = cnt_t'(MAX_VERTICES);

endpackage

// ----- src/mvf_ifs.sv -----
// adjacency row channel
interface mvf_in_if;
  import mvf_pkg::*;
  logic valid;
  logic ready;
  vtx_t row_index;
  row_t row_bits;
  logic last_row;

  modport source (output valid, output row_index, output row_bits, output last_row,
                  input ready);
  modport sink (input valid, input row_index, input row_bits, input last_row,
                output ready);
endinterface

// search result channel
interface mvf_out_if;
  import mvf_pkg::*;
  logic valid;
  logic ready;
  logic found;
  vtx_t mother_vertex;

  modport source (output valid, output found, output mother_vertex, input ready);
  modport sink (input valid, input found, input mother_vertex, output ready);
endinterface

// ----- src/mother_vertex_finder.sv -----
// channel   dir  payload                              transaction
// in_ch     in   row_index, row_bits, last_row        one adjacency row
// out_ch    out  found, mother_vertex                 one result per last row
// cfg_*     in   cfg_wdata (vertex count)             write when cfg_we high
//
// Rows load one per cycle while idle; a row marked last starts the search.
// Search: each scanned vertex slot and each push is a step of its own; a
// backtrack takes a stack memory read (ST_EXAM), then a row memory read
// (ST_POPW); the single read port of the row memory sets this pace.
// Reset is synchronous; row valid flags clear at once, no clearing pass.
// Input is taken only while idle; the result waits in an output register,
// so rows of the next graph load while the previous result is unread.
module mother_vertex_finder (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic [mvf_pkg::CNT_W-1:0] cfg_wdata,
  mvf_in_if.sink              in_ch,
  mvf_out_if.source           out_ch
);
  import mvf_pkg::*;

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_SCAN = 5'b00010,
    ST_EXAM = 5'b00100,
    ST_POPW = 5'b01000,
    ST_DONE = 5'b10000
  } state_t;

  // lowest set bit
  function automatic vtx_t lowest_bit(input row_t x);
    vtx_t r;
    r = '0;
    for (int i = ROW_W - 1; i >= 0; i--) begin
      if (x[i]) r = vtx_t'(i);
    end
    return r;
  endfunction

  state_t state_r, state_nxt;
  cnt_t   count_r;
  row_t   visited_r, visited_nxt;
  row_t   row_vld_r, row_vld_nxt;
  vtx_t   top_r, top_nxt;
  cnt_t   depth_r, depth_nxt;
  vtx_t   last_root_r, last_root_nxt;
  cnt_t   scan_r, scan_nxt;
  logic   pass_two_r, pass_two_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_found_r, out_found_nxt;
  vtx_t   out_vertex_r, out_vertex_nxt;

  // row store and walk stack
  row_t   row_mem [MAX_VERTICES];
  row_t   row_q;
  logic   row_q_vld;
  vtx_t   row_raddr;
  vtx_t   stk_mem [MAX_VERTICES];
  vtx_t   stk_q;
  vtx_t   stk_raddr;
  cnt_t   stk_raddr_full;
  logic   stk_we;
  vtx_t   stk_waddr;
  vtx_t   stk_wdata;

  cnt_t   used_n;
  row_t   use_mask;
  row_t   cand;
  logic   push;
  vtx_t   next_w;
  logic   in_acc;

  // effective vertex count and edge mask
  always_comb begin
    if (count_r == '0) begin
      used_n = cnt_t'(1);
    end else if (count_r > cnt_t'(MAX_VERTICES)) begin
      used_n = cnt_t'(MAX_VERTICES);
    end else begin
      used_n = count_r;
    end
    for (int j = 0; j < ROW_W; j++) begin
      use_mask[j] = (cnt_t'(j) < used_n);
    end
  end

  // unvisited neighbors of the vertex on top of the stack
  always_comb begin
    if (row_q_vld && ({1'b0, top_r} < used_n)) begin
      cand = row_q & use_mask & ~visited_r;
    end else begin
      cand = '0;
    end
  end

  assign push           = (|cand) && (depth_r < cnt_t'(MAX_VERTICES));
  assign next_w         = lowest_bit(cand);
  assign stk_raddr_full = depth_r - cnt_t'(2);
  assign stk_raddr      = stk_raddr_full[VTX_W-1:0];
  assign in_acc         = in_ch.valid && in_ch.ready;

  assign in_ch.ready          = (state_r == ST_IDLE);
  assign out_ch.valid         = out_valid_r;
  assign out_ch.found         = out_found_r;
  assign out_ch.mother_vertex = out_vertex_r;

  // search sequencer
  always_comb begin
    state_nxt      = state_r;
    visited_nxt    = visited_r;
    row_vld_nxt    = row_vld_r;
    top_nxt        = top_r;
    depth_nxt      = depth_r;
    last_root_nxt  = last_root_r;
    scan_nxt       = scan_r;
    pass_two_nxt   = pass_two_r;
    out_valid_nxt  = out_valid_r && !out_ch.ready;
    out_found_nxt  = out_found_r;
    out_vertex_nxt = out_vertex_r;
    row_raddr      = top_r;
    stk_we         = 1'b0;
    stk_waddr      = '0;
    stk_wdata      = top_r;

    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          row_vld_nxt[in_ch.row_index] = 1'b1;
          if (in_ch.last_row) begin
            visited_nxt   = '0;
            last_root_nxt = '0;
            scan_nxt      = '0;
            pass_two_nxt  = 1'b0;
            state_nxt     = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        if (scan_r == used_n) begin
          // pass one over, walk again from the last root
          visited_nxt  = row_t'(1) << last_root_r;
          top_nxt      = last_root_r;
          stk_we       = 1'b1;
          stk_wdata    = last_root_r;
          depth_nxt    = cnt_t'(1);
          row_raddr    = last_root_r;
          pass_two_nxt = 1'b1;
          state_nxt    = ST_EXAM;
        end else if (visited_r[scan_r[VTX_W-1:0]]) begin
          scan_nxt = scan_r + cnt_t'(1);
        end else begin
          // new walk from this vertex
          visited_nxt   = visited_r | (row_t'(1) << scan_r[VTX_W-1:0]);
          top_nxt       = scan_r[VTX_W-1:0];
          last_root_nxt = scan_r[VTX_W-1:0];
          stk_we        = 1'b1;
          stk_wdata     = scan_r[VTX_W-1:0];
          depth_nxt     = cnt_t'(1);
          row_raddr     = scan_r[VTX_W-1:0];
          state_nxt     = ST_EXAM;
        end
      end
      ST_EXAM: begin
        if (push) begin
          visited_nxt = visited_r | (row_t'(1) << next_w);
          stk_we      = 1'b1;
          stk_waddr   = depth_r[VTX_W-1:0];
          stk_wdata   = next_w;
          depth_nxt   = depth_r + cnt_t'(1);
          top_nxt     = next_w;
          row_raddr   = next_w;
        end else begin
          depth_nxt = depth_r - cnt_t'(1);
          if (depth_r == cnt_t'(1)) begin
            if (pass_two_r) begin
              state_nxt = ST_DONE;
            end else begin
              scan_nxt  = scan_r + cnt_t'(1);
              state_nxt = ST_SCAN;
            end
          end else begin
            state_nxt = ST_POPW;
          end
        end
      end
      ST_POPW: begin
        // new top of stack arrives from the stack memory
        top_nxt   = stk_q;
        row_raddr = stk_q;
        state_nxt = ST_EXAM;
      end
      ST_DONE: begin
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt = 1'b1;
          if ((visited_r & use_mask) == use_mask) begin
            out_found_nxt  = 1'b1;
            out_vertex_nxt = last_root_r;
          end else begin
            out_found_nxt  = 1'b0;
            out_vertex_nxt = '0;
          end
          pass_two_nxt = 1'b0;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // row memory
  always_ff @(posedge clk) begin
    if (in_acc) begin
      row_mem[in_ch.row_index] <= in_ch.row_bits;
    end
    row_q     <= row_mem[row_raddr];
    row_q_vld <= row_vld_r[row_raddr];
  end

  // stack memory
  always_ff @(posedge clk) begin
    if (stk_we) begin
      stk_mem[stk_waddr] <= stk_wdata;
    end
    stk_q <= stk_mem[stk_raddr];
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= COUNT_RESET;
      visited_r   <= '0;
      row_vld_r   <= '0;
      depth_r     <= '0;
      last_root_r <= '0;
      scan_r      <= '0;
      pass_two_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      visited_r   <= visited_nxt;
      row_vld_r   <= row_vld_nxt;
      depth_r     <= depth_nxt;
      last_root_r <= last_root_nxt;
      scan_r      <= scan_nxt;
      pass_two_r  <= pass_two_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        count_r <= cfg_wdata;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    top_r        <= top_nxt;
    out_found_r  <= out_found_nxt;
    out_vertex_r <= out_vertex_nxt;
  end

endmodule

// ----- sim/testbench.sv -----
module testbench;
  import mvf_pkg::*;

  localparam int SETTLE_CYCLES  = 8;
  localparam int TAIL_CYCLES    = 200;
  localparam int HOLD_CYCLES    = 400;
  localparam int QUIET_LIMIT    = 5000;
  localparam int RAND_PHASES    = 12;
  localparam int ROWS_PER_PHASE = 75;
  localparam int DIRECTED_N     = 16;

  typedef struct packed {
    logic found;
    vtx_t mother_vertex;
  } result_t;

  // one directed row, with an optional count write before it
  typedef struct packed {
    logic    set_count;
    cnt_t    count_value;
    vtx_t    row_index;
    row_t    row_bits;
    logic    last_row;
    logic    typed;
    result_t typed_res;
  } stim_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  cnt_t cfg_wdata;

  mvf_in_if  rows_ch ();
  mvf_out_if result_ch ();

  mother_vertex_finder i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_ch     (rows_ch),
    .out_ch    (result_ch)
  );

  // shadow of the row store and the vertex count
  row_t    shadow_rows [MAX_VERTICES];
  cnt_t    shadow_count;
  result_t pending_results [$];

  int mismatches;
  int rows_sent;
  int quiet_cycles;
  int send_idle_pct;
  int recv_stall_pct;
  bit hold_req;

  stim_t directed_tbl [DIRECTED_N] = '{
    // reset count of 32: vertex 0 reaches all
    '{1'b0, 6'd0, 5'd0, 32'hffff_ffff, 1'b1, 1'b1, '{1'b1, 5'd0}},
    // no edges at all
    '{1'b0, 6'd0, 5'd0, 32'h0000_0000, 1'b1, 1'b1, '{1'b0, 5'd0}},
    // highest vertex reaches all
    '{1'b0, 6'd0, 5'd31, 32'hffff_ffff, 1'b1, 1'b1, '{1'b1, 5'd31}},
    '{1'b0, 6'd0, 5'd31, 32'h7fff_ffff, 1'b1, 1'b0, '0},
    '{1'b0, 6'd0, 5'd0, 32'h8000_0000, 1'b0, 1'b0, '0},
    '{1'b0, 6'd0, 5'd31, 32'h0000_0001, 1'b1, 1'b0, '0},
    // count zero acts as one vertex
    '{1'b1, 6'd0, 5'd7, 32'hffff_ffff, 1'b1, 1'b1, '{1'b1, 5'd0}},
    '{1'b1, 6'd1, 5'd0, 32'h0000_0000, 1'b1, 1'b1, '{1'b1, 5'd0}},
    '{1'b1, 6'd2, 5'd0, 32'h0000_0002, 1'b0, 1'b0, '0},
    '{1'b0, 6'd0, 5'd1, 32'h0000_0000, 1'b1, 1'b0, '0},
    '{1'b0, 6'd0, 5'd1, 32'hffff_fffd, 1'b1, 1'b0, '0},
    // edges and rows beyond the count
    '{1'b1, 6'd3, 5'd2, 32'hffff_fff8, 1'b1, 1'b0, '0},
    '{1'b0, 6'd0, 5'd30, 32'hffff_ffff, 1'b1, 1'b0, '0},
    // count above the limit acts as the limit
    '{1'b1, 6'd63, 5'd5, 32'haaaa_aaaa, 1'b0, 1'b0, '0},
    '{1'b0, 6'd0, 5'd10, 32'h5555_5555, 1'b1, 1'b0, '0},
    '{1'b1, 6'd33, 5'd16, 32'h0001_0000, 1'b1, 1'b0, '0}
  };

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  task automatic report_mismatch(string what, int got, int want);
    $display("mismatch: %s got %0d want %0d at %0t", what, got, want, $realtime);
    mismatches++;
  endtask

  function automatic int used_count(cnt_t c);
    if (c == 0) return 1;
    if (c > MAX_VERTICES) return MAX_VERTICES;
    return int'(c);
  endfunction

  // depth-first walk with an explicit stack, lowest neighbour first
  function automatic row_t reach_from(int root, int n, row_t seen);
    int   walk [MAX_VERTICES];
    int   depth;
    int   v;
    int   w;
    row_t cand;
    row_t m;
    m = row_t'((64'd1 << n) - 64'd1);
    seen[root] = 1'b1;
    walk[0] = root;
    depth = 1;
    while (depth > 0) begin
      v = walk[depth - 1];
      cand = (v < n) ? (shadow_rows[v] & m & ~seen) : '0;
      if (cand != '0 && depth < MAX_VERTICES) begin
        w = 0;
        while (!cand[w]) w++;
        seen[w] = 1'b1;
        walk[depth] = w;
        depth++;
      end else begin
        depth--;
      end
    end
    return seen;
  endfunction

  // pass one finds the last root, pass two checks that it reaches all
  function automatic result_t predict_mother();
    int      n;
    int      root;
    row_t    seen;
    row_t    m;
    result_t r;
    n = used_count(shadow_count);
    m = row_t'((64'd1 << n) - 64'd1);
    seen = '0;
    root = 0;
    for (int s = 0; s < n; s++) begin
      if (!seen[s]) begin
        seen = reach_from(s, n, seen);
        root = s;
      end
    end
    seen = reach_from(root, n, '0);
    r.found = ((seen & m) == m);
    r.mother_vertex = r.found ? vtx_t'(root) : '0;
    return r;
  endfunction

  function automatic void shuffle_order(ref int order [MAX_VERTICES], input int len);
    int j;
    int t;
    for (int i = len - 1; i > 0; i--) begin
      j = $urandom_range(i, 0);
      t = order[i];
      order[i] = order[j];
      order[j] = t;
    end
  endfunction

  // offer one row at a falling edge, return at the falling edge after acceptance
  task automatic send_row(vtx_t idx, row_t bits, logic last, logic typed = 1'b0,
                          result_t typed_res = '0);
    result_t r;
    while (send_idle_pct != 0 && $urandom_range(99, 0) < send_idle_pct) begin
      rows_ch.valid <= 1'b0;
      @(negedge clk);
    end
    rows_ch.valid     <= 1'b1;
    rows_ch.row_index <= idx;
    rows_ch.row_bits  <= bits;
    rows_ch.last_row  <= last;
    do @(posedge clk); while (!rows_ch.ready);
    shadow_rows[idx] = bits;
    rows_sent++;
    if (last) begin
      r = predict_mother();
      pending_results.push_back(typed ? typed_res : r);
    end
    @(negedge clk);
  endtask

  // drain all results, then let trailing row loads settle
  task automatic wait_idle();
    rows_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_count(cnt_t value);
    cfg_wdata <= value;
    cfg_we    <= 1'b1;
    @(negedge clk);
    cfg_we    <= 1'b0;
    shadow_count = value;
  endtask

  // one graph: mostly rooted trees with extra edges, also random and partial rows
  task automatic send_graph();
    row_t g [MAX_VERTICES];
    int   order [MAX_VERTICES];
    int   n;
    int   shape;
    int   parent;
    int   count;
    int   k;
    row_t bits;
    vtx_t idx;
    n = used_count(shadow_count);
    shape = $urandom_range(9, 0);
    for (int v = 0; v < MAX_VERTICES; v++) begin
      g[v] = '0;
      order[v] = v;
    end
    if (shape <= 5) begin
      shuffle_order(order, n);
      for (int i = 1; i < n; i++) begin
        parent = order[$urandom_range(i - 1, 0)];
        g[parent][order[i]] = 1'b1;
      end
      for (int v = 0; v < n; v++) begin
        if ($urandom_range(3, 0) == 0) g[v] |= $urandom & $urandom & $urandom;
      end
      // stray row past the count
      if (n < MAX_VERTICES && $urandom_range(3, 0) == 0)
        send_row(vtx_t'($urandom_range(MAX_VERTICES - 1, n)), $urandom, 1'b0);
      for (int v = 0; v < MAX_VERTICES; v++) order[v] = v;
      shuffle_order(order, n);
      for (int i = 0; i < n; i++)
        send_row(vtx_t'(order[i]), g[order[i]], i == n - 1);
    end else if (shape <= 8) begin
      count = (shape == 8) ? $urandom_range(3, 1) : $urandom_range(n, 1);
      k = $urandom_range(3, 0);
      for (int i = 0; i < count; i++) begin
        bits = $urandom;
        repeat (k) bits &= $urandom;
        if ($urandom_range(3, 0) == 0) idx = vtx_t'($urandom_range(MAX_VERTICES - 1, 0));
        else idx = vtx_t'($urandom_range(n - 1, 0));
        send_row(idx, bits, i == count - 1);
      end
    end else begin
      // noise rows, may end without a search
      count = $urandom_range(4, 1);
      for (int i = 0; i < count; i++)
        send_row(vtx_t'($urandom_range(MAX_VERTICES - 1, 0)), $urandom,
                 (i == count - 1) && ($urandom_range(1, 0) == 1));
    end
  endtask

  // result receiver with random stalls and one long hold-off
  initial begin
    result_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        result_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_req = 1'b0;
      end
      result_ch.ready <= ($urandom_range(99, 0) >= recv_stall_pct);
    end
  end

  // result check against the oldest pending search
  always @(posedge clk) begin
    result_t want;
    if (rst_n && result_ch.valid && result_ch.ready) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result, found", result_ch.found, 0);
      end else begin
        want = pending_results.pop_front();
        if (result_ch.found !== want.found)
          report_mismatch("found", result_ch.found, want.found);
        if (result_ch.mother_vertex !== want.mother_vertex)
          report_mismatch("mother_vertex", result_ch.mother_vertex, want.mother_vertex);
      end
    end
  end

  // watchdog on cycles without any transaction
  always @(posedge clk) begin
    if (!rst_n || (rows_ch.valid && rows_ch.ready) || (result_ch.valid && result_ch.ready)
        || cfg_we) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // stimulus
  initial begin
    int target;
    rst_n             = 1'b0;
    cfg_we            = 1'b0;
    cfg_wdata         = '0;
    rows_ch.valid     = 1'b0;
    rows_ch.row_index = '0;
    rows_ch.row_bits  = '0;
    rows_ch.last_row  = 1'b0;
    mismatches        = 0;
    rows_sent         = 0;
    quiet_cycles      = 0;
    send_idle_pct     = 0;
    recv_stall_pct    = 0;
    hold_req          = 1'b0;
    shadow_count      = COUNT_RESET;
    for (int v = 0; v < MAX_VERTICES; v++) shadow_rows[v] = '0;
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed table
    foreach (directed_tbl[i]) begin
      if (directed_tbl[i].set_count) begin
        wait_idle();
        write_count(directed_tbl[i].count_value);
      end
      send_row(directed_tbl[i].row_index, directed_tbl[i].row_bits, directed_tbl[i].last_row,
               directed_tbl[i].typed, directed_tbl[i].typed_res);
    end

    // random phases over counts and idle patterns
    for (int phase = 0; phase < RAND_PHASES; phase++) begin
      wait_idle();
      case (phase)
        0:       write_count(6'd63);
        1:       write_count(6'd0);
        2:       write_count(6'd1);
        3:       write_count(6'd2);
        4:       write_count(6'd5);
        5:       write_count(6'd8);
        6:       write_count(6'd32);
        7:       write_count(6'd33);
        8:       write_count(6'd3);
        9:       write_count(6'd16);
        10:      write_count(cnt_t'($urandom_range(63, 0)));
        default: write_count(6'd32);
      endcase
      case (phase % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 62; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 62; end
        default: begin send_idle_pct = 20; recv_stall_pct = 20; end
      endcase
      if (phase == 4) hold_req = 1'b1;
      target = rows_sent + ROWS_PER_PHASE;
      while (rows_sent < target) send_graph();
    end

    wait_idle();
    repeat (TAIL_CYCLES) @(negedge clk);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
